### rtl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package u16u8_pkg;

   localparam int MaxBytes  = 7;
   localparam int CountW    = $clog2(MaxBytes + 1);
   localparam int QueueDepth = 2;

   localparam logic [15:0] SurrHighLo = 16'hD800;
   localparam logic [15:0] SurrHighHi = 16'hDBFF;
   localparam logic [15:0] SurrLowLo  = 16'hDC00;
   localparam logic [15:0] SurrLowHi  = 16'hDFFF;
   localparam logic [15:0] Lim1Byte   = 16'h0080;
   localparam logic [15:0] Lim2Byte   = 16'h0800;
   localparam logic [10:0] PlaneOfs   = 11'h040;   // 0x10000 >> 10
   localparam logic [7:0]  Lead2      = 8'hC0;
   localparam logic [7:0]  Lead3      = 8'hE0;
   localparam logic [7:0]  Lead4      = 8'hF0;
   localparam logic [7:0]  ContMark   = 8'h80;
   localparam logic [7:0]  FlushLead  = 8'hED;
   localparam logic [7:0]  FlushMid   = 8'hA0;
   localparam logic [7:0]  NulByte    = 8'h00;

   // One unit's worth of output bytes, in emission order from index 0.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountW-1:0]        count;
      logic                     has_nul;
   } job_type;

endpackage

### rtl/u16u8_front.sv
// Front end: accepts code units, tracks surrogate and skip state, and
// builds the byte list for each unit. Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [15:0]       code_unit,
   input  logic              last_unit,
   output logic              job_valid,
   output u16u8_pkg::job_type job
);
   import u16u8_pkg::*;

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_bits_ff, held_bits_in;
   logic       skip_ff, skip_in;

   logic        is_low, is_high;
   logic [10:0] plane;
   logic [CountW-1:0] n;

   assign is_low  = (code_unit >= SurrLowLo) && (code_unit <= SurrLowHi);
   assign is_high = (code_unit >= SurrHighLo) && (code_unit <= SurrHighHi);
   assign plane   = {1'b0, held_bits_ff} + PlaneOfs;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      skip_in       = skip_ff;
      job.bytes     = '0;
      job.has_nul   = 1'b0;
      n             = '0;
      if (skip_ff) begin
         if (last_unit) begin
            skip_in = 1'b0;
         end
      end else if (held_valid_ff && is_low) begin
         held_valid_in = 1'b0;
         job.bytes[0] = Lead4 | {5'd0, plane[10:8]};
         job.bytes[1] = ContMark | {2'd0, plane[7:2]};
         job.bytes[2] = ContMark | {2'd0, plane[1:0], code_unit[9:6]};
         job.bytes[3] = ContMark | {2'd0, code_unit[5:0]};
         n = CountW'(4);
         if (last_unit) begin
            job.bytes[n] = NulByte;
            job.has_nul  = 1'b1;
            n = n + 1'b1;
         end
      end else begin
         if (held_valid_ff) begin
            // flush the unpaired high surrogate as three bytes
            held_valid_in = 1'b0;
            job.bytes[0] = FlushLead;
            job.bytes[1] = FlushMid | {4'd0, held_bits_ff[9:6]};
            job.bytes[2] = ContMark | {2'd0, held_bits_ff[5:0]};
            n = CountW'(3);
         end
         if (code_unit == 16'd0) begin
            job.bytes[n] = NulByte;
            job.has_nul  = 1'b1;
            n = n + 1'b1;
            if (!last_unit) begin
               skip_in = 1'b1;
            end
         end else if (code_unit < Lim1Byte) begin
            job.bytes[n] = code_unit[7:0];
            n = n + 1'b1;
         end else if (code_unit < Lim2Byte) begin
            job.bytes[n] = Lead2 | {3'd0, code_unit[10:6]};
            n = n + 1'b1;
            job.bytes[n] = ContMark | {2'd0, code_unit[5:0]};
            n = n + 1'b1;
         end else if (is_high && !last_unit) begin
            held_valid_in = 1'b1;
            held_bits_in  = code_unit[9:0];
         end else begin
            job.bytes[n] = Lead3 | {4'd0, code_unit[15:12]};
            n = n + 1'b1;
            job.bytes[n] = ContMark | {2'd0, code_unit[11:6]};
            n = n + 1'b1;
            job.bytes[n] = ContMark | {2'd0, code_unit[5:0]};
            n = n + 1'b1;
         end
         if (last_unit && (code_unit != 16'd0)) begin
            job.bytes[n] = NulByte;
            job.has_nul  = 1'b1;
            n = n + 1'b1;
         end
      end
      job.count = n;
      job_valid = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
         skip_ff       <= 1'b0;
      end else if (accept) begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
         skip_ff       <= skip_in;
      end
   end

endmodule

### rtl/u16u8_queue.sv
// Two-entry job queue between the front end and the byte serializer.
// Depends on u16u8_pkg for the job type and depth.
`timescale 1ns / 1ps

module u16u8_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  u16u8_pkg::job_type wr_job,
   input  logic              rd_en,
   output u16u8_pkg::job_type rd_job,
   output logic              q_empty,
   output logic              q_full
);
   import u16u8_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   job_type            slot_ff [QueueDepth];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]      count_ff, count_in;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == (PtrW + 1)'(QueueDepth));
   assign rd_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

### rtl/u16u8_back.sv
// Back end: takes jobs from the queue and streams their bytes, one per
// cycle while the output register is free, into the result output register. Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  u16u8_pkg::job_type q_job,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output logic [7:0]        out_byte,
   output logic              run_last,
   output logic              string_end
);
   import u16u8_pkg::*;

   logic              cur_valid_ff;
   job_type           cur_job_ff;
   logic [CountW-1:0] idx_ff;

   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff, out_end_ff;

   logic out_free, emit, cur_last, cur_take;

   assign out_free = !out_valid_ff || pop;
   assign emit     = cur_valid_ff && out_free;
   assign cur_last = (idx_ff == cur_job_ff.count - 1'b1);
   assign cur_take = !cur_valid_ff || (emit && cur_last);
   assign q_pop    = cur_take && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (cur_take) begin
         cur_valid_ff <= !q_empty;
         idx_ff       <= '0;
      end else if (emit) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_job_ff <= q_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= cur_job_ff.bytes[idx_ff];
         out_last_ff <= cur_last;
         out_end_ff  <= cur_last && cur_job_ff.has_nul;
      end
   end

   assign empty      = !out_valid_ff;
   assign out_byte   = out_byte_ff;
   assign run_last   = out_last_ff;
   assign string_end = out_end_ff;

endmodule

### rtl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue and byte
// serializer. Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
`timescale 1ns / 1ps

// Usage:
// Push one UTF-16 code unit per transaction on req_code_unit with
// req_last_unit marking the final unit of a buffer; a transaction happens
// when push is high and full is low. Results come out as a queue: while
// empty is low, rsp_out_byte, rsp_run_last and rsp_string_end show the
// oldest byte, taken when pop is high.
// Each unit becomes a job of zero to seven bytes, built in the cycle it is
// accepted and held in a two-entry job queue. The serializer sends one byte
// per cycle while pop keeps the output register free; a job passes from its
// queue slot to the current-job register and then byte by byte to the
// output register. The input rate is set by the byte rate of the
// serializer, so multi-byte units slow it; ASCII runs at one unit per cycle
// while pop stays high.
// Units that give no bytes (a held high surrogate, units after a
// terminator) still pass through full but take no queue slot.
// Reset clears the surrogate and skip state, the queue and the output
// register. When pop stays low the output byte holds, the queue fills and
// full rises.
module utf16_to_utf8_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);
   import u16u8_pkg::*;

   logic    accept;
   logic    job_valid;
   job_type front_job, head_job;
   logic    q_empty, q_full, q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   u16u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_unit (req_code_unit),
      .last_unit (req_last_unit),
      .job_valid (job_valid),
      .job       (front_job)
   );

   u16u8_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_valid),
      .wr_job  (front_job),
      .rd_en   (q_pop),
      .rd_job  (head_job),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .pop        (pop),
      .empty      (empty),
      .out_byte   (rsp_out_byte),
      .run_last   (rsp_run_last),
      .string_end (rsp_string_end)
   );

   // the terminator always closes its unit's byte run
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_string_end) |-> rsp_run_last)
      else $error("string_end without run_last");

   // a zero byte is only ever the terminator
   a_zero_is_nul: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_out_byte == 8'h00)) |-> rsp_string_end)
      else $error("zero byte not marked as string end");

   a_nul_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_string_end) |-> (rsp_out_byte == 8'h00))
      else $error("string end byte is not zero");

   // reset empties the result side
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result pending right after reset");

endmodule

### tb/utf8_byte_checker.sv
// Scoreboard for the UTF-16 to UTF-8 encoder: watches the code unit and byte
// queue interfaces, predicts the UTF-8 byte stream and compares every byte.
// Standalone; instantiated by utf16_to_utf8_encoder_test.
`timescale 1ns / 1ps

module utf8_byte_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_last,
   input  logic        rsp_string_end,
   output int          mismatch_count,
   output int          waiting_bytes,
   output int          checked_bytes
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } utf8_byte_type;

   utf8_byte_type expected_bytes[$];

   // Encoder state: pending high surrogate and skip-to-end-of-buffer flag.
   logic       high_pending = 1'b0;
   logic [9:0] high_bits    = '0;
   logic       skipping     = 1'b0;

   int errors  = 0;
   int checked = 0;

   function automatic logic [23:0] three_byte_form(input logic [15:0] u);
      return {4'hE, u[15:12], 2'b10, u[11:6], 2'b10, u[5:0]};
   endfunction

   task automatic encode_unit(input logic [15:0] unit, input logic last);
      logic [7:0]    seq[$];
      logic [23:0]   triple;
      logic [20:0]   code_point;
      logic          with_nul;
      utf8_byte_type entry;
      with_nul = 1'b0;
      if (skipping) begin
         if (last) skipping = 1'b0;
         return;
      end
      if (high_pending && unit >= 16'hDC00 && unit <= 16'hDFFF) begin
         code_point = 21'h10000 + {high_bits, 10'd0} + (unit - 16'hDC00);
         high_pending = 1'b0;
         seq.push_back({5'b11110, code_point[20:18]});
         seq.push_back({2'b10, code_point[17:12]});
         seq.push_back({2'b10, code_point[11:6]});
         seq.push_back({2'b10, code_point[5:0]});
      end else begin
         // Flush an unpaired high surrogate as its own three bytes.
         if (high_pending) begin
            triple = three_byte_form({6'b110110, high_bits});
            seq.push_back(triple[23:16]);
            seq.push_back(triple[15:8]);
            seq.push_back(triple[7:0]);
            high_pending = 1'b0;
         end
         if (unit == 16'h0000) begin
            seq.push_back(8'h00);
            with_nul = 1'b1;
            if (!last) skipping = 1'b1;
         end else if (unit < 16'h0080) begin
            seq.push_back(unit[7:0]);
         end else if (unit < 16'h0800) begin
            seq.push_back({3'b110, unit[10:6]});
            seq.push_back({2'b10, unit[5:0]});
         end else if (unit >= 16'hD800 && unit <= 16'hDBFF && !last) begin
            high_pending = 1'b1;
            high_bits    = unit[9:0];
         end else begin
            triple = three_byte_form(unit);
            seq.push_back(triple[23:16]);
            seq.push_back(triple[15:8]);
            seq.push_back(triple[7:0]);
         end
      end
      if (last && !with_nul) begin
         seq.push_back(8'h00);
         with_nul = 1'b1;
      end
      foreach (seq[i]) begin
         entry.out_byte   = seq[i];
         entry.run_last   = (i == seq.size() - 1);
         entry.string_end = with_nul && (i == seq.size() - 1);
         expected_bytes.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      utf8_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         high_pending = 1'b0;
         high_bits    = '0;
         skipping     = 1'b0;
      end else begin
         if (pop && !empty) begin
            checked++;
            if (expected_bytes.size() == 0) begin
               if (errors < 10)
                  $display("byte %0d: unexpected output %02h run_last %0b string_end %0b",
                           checked, rsp_out_byte, rsp_run_last, rsp_string_end);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_run_last !== want.run_last ||
                   rsp_string_end !== want.string_end) begin
                  if (errors < 10)
                     $display("byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                              checked, want.out_byte, want.run_last, want.string_end,
                              rsp_out_byte, rsp_run_last, rsp_string_end);
                  errors++;
               end
            end
         end
         if (push && !full) encode_unit(req_code_unit, req_last_unit);
      end
      mismatch_count <= errors;
      waiting_bytes  <= expected_bytes.size();
      checked_bytes  <= checked;
   end

endmodule

### tb/utf16_to_utf8_encoder_test.sv
// Top of the encoder testbench: clock, reset, code unit stimulus and byte
// drain with random stalls. Depends on utf16_to_utf8_encoder, utf8_byte_checker.
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_test;

   localparam int CycleLimit   = 600000;
   localparam int RandomTarget = 240;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        push           = 1'b0;
   logic        full;
   logic [15:0] req_code_unit  = '0;
   logic        req_last_unit  = 1'b0;
   logic        empty;
   logic        pop            = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_end;

   int mismatch_count;
   int waiting_bytes;
   int checked_bytes;

   int   cycle_count   = 0;
   int   units_sent    = 0;
   int   units_ignored = 0;
   int   quiet_left    = 0;
   logic tail_skip     = 1'b0;

   utf16_to_utf8_encoder DUT (
      .clock, .reset, .push, .full, .req_code_unit, .req_last_unit,
      .empty, .pop, .rsp_out_byte, .rsp_run_last, .rsp_string_end
   );

   utf8_byte_checker u_checker (
      .clock, .reset, .push, .full, .req_code_unit, .req_last_unit,
      .empty, .pop, .rsp_out_byte, .rsp_run_last, .rsp_string_end,
      .mismatch_count, .waiting_bytes, .checked_bytes
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run timed out after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic idle_sender();
      int gap;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(20, 50);
         gap = gap_length();
      end
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the transaction until full is low at an edge; push stays high after.
   task automatic send_unit(input logic [15:0] unit, input logic last);
      push          <= 1'b1;
      req_code_unit <= unit;
      req_last_unit <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      units_sent++;
      if (tail_skip) begin
         units_ignored++;
         if (last) tail_skip = 1'b0;
      end else if (unit == 16'h0000 && !last) begin
         tail_skip = 1'b1;
      end
      idle_sender();
   endtask

   task automatic send_string();
      logic [15:0] units[$];
      int          len;
      int          pick;
      int          r;
      len = $urandom_range(1, 12);
      repeat (len) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            units.push_back(16'($urandom_range(1, 16'h007F)));
         end else if (pick < 40) begin
            units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
         end else if (pick < 65) begin
            // Skip over the surrogate range.
            r = $urandom_range(16'h0800, 16'hF7FF);
            if (r >= 16'hD800) r = r + 16'h0800;
            units.push_back(16'(r));
         end else if (pick < 85) begin
            units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
            units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
         end else if (pick < 90) begin
            units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
         end else if (pick < 95) begin
            units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
         end else begin
            units.push_back(16'h0000);
         end
      end
      foreach (units[i]) send_unit(units[i], i == units.size() - 1);
   endtask

   // Drain side: long open stretches and bursts broken by random stalls.
   initial begin
      int hold;
      int rest;
      forever begin
         if ($urandom_range(0, 7) == 0) hold = $urandom_range(40, 120);
         else hold = $urandom_range(1, 10);
         pop <= 1'b1;
         repeat (hold) @(posedge clock);
         rest = gap_length();
         if (rest > 0) begin
            pop <= 1'b0;
            repeat (rest) @(posedge clock);
         end
      end
   end

   initial begin
      int random_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Range edges of the 1-, 2- and 3-byte forms.
      send_unit(16'h0001, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      // Lowest and highest surrogate pairs.
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b0);
      // Held high surrogate followed by ASCII: flush, then the unit.
      send_unit(16'hD801, 1'b0);
      send_unit(16'h0041, 1'b0);
      // High after high: flush the first, pair the second.
      send_unit(16'hDA00, 1'b0);
      send_unit(16'hDB00, 1'b0);
      send_unit(16'hDC01, 1'b0);
      // Lone low surrogate.
      send_unit(16'hDFFF, 1'b0);
      // High surrogate on the last unit encodes at once, then NUL.
      send_unit(16'hDBFF, 1'b1);
      // Held surrogate flushed by the last unit.
      send_unit(16'hD800, 1'b0);
      send_unit(16'h0042, 1'b1);
      // Held surrogate flushed by a terminator, then the tail is dropped.
      send_unit(16'hD812, 1'b0);
      send_unit(16'h0000, 1'b0);
      send_unit(16'h0041, 1'b1);
      // Terminator on the last unit: NUL only, no skipping.
      send_unit(16'h0000, 1'b1);
      // Pair that closes the buffer.
      send_unit(16'hD83D, 1'b0);
      send_unit(16'hDE00, 1'b1);

      random_start = units_sent - units_ignored;
      while ((units_sent - units_ignored) - random_start < RandomTarget) begin
         if ($urandom_range(0, 9) < 8) begin
            send_string();
         end else begin
            repeat ($urandom_range(1, 6))
               send_unit(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) == 0);
         end
      end
      push <= 1'b0;

      @(posedge clock);
      while (waiting_bytes != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Drove %0d code units (%0d dropped after a terminator): range edges,",
               units_sent, units_ignored);
      $display("surrogate pairs and strays, terminators, random strings; %0d bytes compared.",
               checked_bytes);
      if (waiting_bytes != 0)
         $display("%0d expected bytes never came out", waiting_bytes);
      if (mismatch_count == 0 && waiting_bytes == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
